// ===== hdl/audio_gain_soft_limiter_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the gain stage with soft limiter
// Concurrent checks clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef AUDIO_GAIN_SOFT_LIMITER_DEFINES_SVH
`define AUDIO_GAIN_SOFT_LIMITER_DEFINES_SVH

// same-cycle implication
`define AGSL_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("agsl: same-cycle check failed");

// next-cycle implication
`define AGSL_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("agsl: next-cycle check failed");

`endif

// ===== hdl/agsl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agsl_pkg
// Shared types and constants of the gain stage with soft limiter.
// ----------------------------------------------------------------------------
package agsl_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int TANH_DEPTH_DEF   = 256;

  localparam int GAIN_W   = 16;
  localparam int PCM_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;
  localparam logic [GAIN_W-1:0] GAIN_MAX   = 16'd61440;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN       = 2'd0,
    CFG_BOOSTER    = 2'd1,
    CFG_BIG_ENDIAN = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic              booster;
    logic              big_endian;
  } agsl_cfg_t;

endpackage

// ===== hdl/agsl_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agsl_pipe
// Five-stage gain and tanh soft-knee datapath with per-stage valid bits;
// the final clamp, sign and byte order are combinational after stage five.
// ----------------------------------------------------------------------------
module agsl_pipe #(
  parameter int SAMPLE_WIDTH     = agsl_pkg::SAMPLE_WIDTH_DEF,
  parameter int TANH_TABLE_DEPTH = agsl_pkg::TANH_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  agsl_pkg::agsl_cfg_t            cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           channel_i,
  input  logic                           last_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [agsl_pkg::PCM_W-1:0]     pcm_word_o,
  output logic                           channel_o,
  output logic                           last_o
);

  localparam int W    = SAMPLE_WIDTH;
  localparam int F    = W + 11;
  localparam int MW   = W + 16;
  localparam int FW   = F - 6;
  localparam int KL   = (FW + 1) / 2;
  localparam int KH   = FW - KL;
  localparam int IXW  = MW - FW;
  localparam int AW   = (TANH_TABLE_DEPTH > 1) ? $clog2(TANH_TABLE_DEPTH) : 1;
  localparam int IW   = (AW > IXW) ? AW : IXW;
  localparam int QW   = 31;
  localparam int DW   = 26;
  localparam int LW   = MW + 15 - F;
  localparam int GAIN_W_L = agsl_pkg::GAIN_W;
  localparam int PCM_W_L  = agsl_pkg::PCM_W;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] TANH_C  = 64'd33543514;
  localparam logic [MW-1:0] KNEE  = MW'(1) << (F - 1);

  typedef logic [TANH_TABLE_DEPTH-1:0][QW-1:0] tanh_rom_t;

  function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic tanh_rom_t build_tanh_rom();
    tanh_rom_t   rom;
    logic [63:0] t;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] nt;
    rom = '0;
    t   = '0;
    for (int k = 1; k < TANH_TABLE_DEPTH; k++) begin
      num = (t + TANH_C) << 30;
      den = Q30_ONE + ((t * TANH_C) >> 30);
      nt  = div_u64(num + (den >> 1), den);
      if (nt > Q30_ONE) nt = Q30_ONE;
      if (nt < t) nt = t;
      t = nt;
      rom[k] = t[QW-1:0];
    end
    return rom;
  endfunction

  localparam tanh_rom_t TanhRom = build_tanh_rom();

  // stage valids
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !s5_v_q || out_ready_i;
  assign rdy4 = !s4_v_q || rdy5;
  assign rdy3 = !s3_v_q || rdy4;
  assign rdy2 = !s2_v_q || rdy3;
  assign rdy1 = !s1_v_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else begin
      if (rdy1) s1_v_q <= in_valid_i;
      if (rdy2) s2_v_q <= s1_v_q;
      if (rdy3) s3_v_q <= s2_v_q;
      if (rdy4) s4_v_q <= s3_v_q;
      if (rdy5) s5_v_q <= s4_v_q;
    end
  end

  // side fields carried along
  logic [2:0] s1_side_q, s2_side_q, s3_side_q, s4_side_q, s5_side_q;

  // stage 1: sign and magnitude
  logic [W-1:0] s1_mag_q;
  logic [W-1:0] mag_d;

  assign mag_d = sample_i[W-1] ? (~sample_i + W'(1)) : sample_i;

  // stage 2: gain product
  logic [MW-1:0]       s2_m_q;
  logic [GAIN_W_L-1:0] gain_lim;
  logic [MW-1:0]       prod;
  logic [MW-1:0]       m_d;

  assign gain_lim = (cfg_i.gain > agsl_pkg::GAIN_MAX) ? agsl_pkg::GAIN_MAX : cfg_i.gain;
  assign prod     = MW'(s1_mag_q) * MW'(gain_lim);
  assign m_d      = cfg_i.booster ? (prod << 1) : prod;

  // stage 3: knee split, table lookup, linear scale
  logic            knee_d;
  logic [MW-1:0]   over_knee;
  logic [IXW-1:0]  seg;
  logic [IW-1:0]   seg_ext;
  logic            in_table;
  logic [AW-1:0]   idx, idx_nx;
  logic [QW-1:0]   lo_d;
  logic [DW-1:0]   diff_d;
  logic [MW+14:0]  lin_prod;
  logic [LW-1:0]   lin_full;
  logic [14:0]     lin_d;

  assign knee_d    = cfg_i.booster && (s2_m_q > KNEE);
  assign over_knee = s2_m_q - KNEE;
  assign seg       = over_knee[MW-1:FW];
  assign seg_ext   = IW'(seg);
  assign in_table  = seg_ext < IW'(TANH_TABLE_DEPTH - 1);
  assign idx       = seg_ext[AW-1:0];
  assign idx_nx    = idx + AW'(1);

  always_comb begin
    if (in_table) begin
      lo_d   = TanhRom[idx];
      diff_d = DW'(TanhRom[idx_nx] - TanhRom[idx]);
    end else begin
      lo_d   = QW'(Q30_ONE);
      diff_d = '0;
    end
  end

  assign lin_prod = {s2_m_q, 15'b0} - (MW + 15)'(s2_m_q);
  assign lin_full = lin_prod[MW+14:F];
  assign lin_d    = (|lin_full[LW-1:15]) ? 15'h7fff : lin_full[14:0];

  logic            s3_knee_q;
  logic [14:0]     s3_lin_q;
  logic [QW-1:0]   s3_lo_q;
  logic [DW-1:0]   s3_diff_q;
  logic [FW-1:0]   s3_frac_q;

  // stage 4: split interpolation product
  logic [DW+KL-1:0] plo_d;
  logic [DW+KH-1:0] phi_d;

  assign plo_d = (DW + KL)'(s3_diff_q) * (DW + KL)'(s3_frac_q[KL-1:0]);
  assign phi_d = (DW + KH)'(s3_diff_q) * (DW + KH)'(s3_frac_q[FW-1:KL]);

  logic             s4_knee_q;
  logic [14:0]      s4_lin_q;
  logic [QW-1:0]    s4_lo_q;
  logic [DW+KL-1:0] s4_plo_q;
  logic [DW+KH-1:0] s4_phi_q;

  // stage 5: interpolated tanh
  logic [DW+FW:0] psum;
  logic [QW-1:0]  th_d;

  assign psum = ((DW + FW + 1)'(s4_phi_q) << KL) + (DW + FW + 1)'(s4_plo_q);
  assign th_d = s4_lo_q + QW'(psum[DW+FW:FW]);

  logic          s5_knee_q;
  logic [14:0]   s5_lin_q;
  logic [QW-1:0] s5_th_q;

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      s1_mag_q  <= mag_d;
      s1_side_q <= {sample_i[W-1], channel_i, last_i};
    end
    if (rdy2 && s1_v_q) begin
      s2_m_q    <= m_d;
      s2_side_q <= s1_side_q;
    end
    if (rdy3 && s2_v_q) begin
      s3_knee_q <= knee_d;
      s3_lin_q  <= lin_d;
      s3_lo_q   <= lo_d;
      s3_diff_q <= diff_d;
      s3_frac_q <= over_knee[FW-1:0];
      s3_side_q <= s2_side_q;
    end
    if (rdy4 && s3_v_q) begin
      s4_knee_q <= s3_knee_q;
      s4_lin_q  <= s3_lin_q;
      s4_lo_q   <= s3_lo_q;
      s4_plo_q  <= plo_d;
      s4_phi_q  <= phi_d;
      s4_side_q <= s3_side_q;
    end
    if (rdy5 && s4_v_q) begin
      s5_knee_q <= s4_knee_q;
      s5_lin_q  <= s4_lin_q;
      s5_th_q   <= th_d;
      s5_side_q <= s4_side_q;
    end
  end

  // final scale, sign and byte order
  logic [31:0]          knee_sum;
  logic [46:0]          knee_prod;
  logic [15:0]          knee_full;
  logic [14:0]          knee_v;
  logic [14:0]          val;
  logic [PCM_W_L-1:0]   word;

  assign knee_sum  = 32'(Q30_ONE) + 32'(s5_th_q);
  assign knee_prod = {knee_sum, 15'b0} - 47'(knee_sum);
  assign knee_full = knee_prod[46:31];
  assign knee_v    = knee_full[15] ? 15'h7fff : knee_full[14:0];
  assign val       = s5_knee_q ? knee_v : s5_lin_q;
  assign word      = s5_side_q[2] ? (~{1'b0, val} + 16'd1) : {1'b0, val};

  assign out_valid_o = s5_v_q;
  assign pcm_word_o  = cfg_i.big_endian ? {word[7:0], word[15:8]} : word;
  assign channel_o   = s5_side_q[1];
  assign last_o      = s5_side_q[0];

endmodule

// ===== hdl/audio_gain_soft_limiter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_gain_soft_limiter
// Applies a Q4.12 gain to Q1.23 samples, with optional doubling that also enables a tanh
// soft knee past one half, and emits clamped 16-bit PCM words.
//
//   channel   direction  handshake               beat
//   in        sink       in_valid_i / in_stall_o  sample_in_i, channel_i, last_in_i
//   out       source     out_valid_o / out_stall_i pcm_word_o, channel_out_o, last_out_o
//   cfg       sink       cfg_we_i                 cfg_idx_i, cfg_data_i
//
// One beat per cycle sustained while out_stall_i is low; an input beat passes
// through five datapath stages, the first loading on the accepting edge,
// and then through the output register.
// A two-entry output register with skid keeps out_stall_i off the input path.
// Reset clears all valid bits and loads the register defaults.
// Configuration is taken on any cycle with cfg_we_i high.
// ----------------------------------------------------------------------------
`include "audio_gain_soft_limiter_defines.svh"

module audio_gain_soft_limiter #(
  parameter int SAMPLE_WIDTH     = agsl_pkg::SAMPLE_WIDTH_DEF,
  parameter int TANH_TABLE_DEPTH = agsl_pkg::TANH_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [agsl_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [agsl_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_in_i,
  input  logic                                channel_i,
  input  logic                                last_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [agsl_pkg::PCM_W-1:0]          pcm_word_o,
  output logic                                channel_out_o,
  output logic                                last_out_o
);

  agsl_pkg::agsl_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain       <= agsl_pkg::GAIN_RESET;
      cfg_q.booster    <= 1'b0;
      cfg_q.big_endian <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        agsl_pkg::CFG_GAIN:       cfg_q.gain       <= cfg_data_i;
        agsl_pkg::CFG_BOOSTER:    cfg_q.booster    <= cfg_data_i[0];
        agsl_pkg::CFG_BIG_ENDIAN: cfg_q.big_endian <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic                         in_ready;
  logic                         pipe_valid;
  logic                         pipe_ready;
  logic [agsl_pkg::PCM_W-1:0]   pipe_word;
  logic                         pipe_ch;
  logic                         pipe_last;

  assign in_stall_o = !in_ready;

  agsl_pipe #(
    .SAMPLE_WIDTH     (SAMPLE_WIDTH),
    .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
  ) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .sample_i    (sample_in_i),
    .channel_i   (channel_i),
    .last_i      (last_in_i),
    .out_valid_o (pipe_valid),
    .out_ready_i (pipe_ready),
    .pcm_word_o  (pipe_word),
    .channel_o   (pipe_ch),
    .last_o      (pipe_last)
  );

  // output register with skid
  logic                       out_valid_q;
  logic                       skid_valid_q;
  logic [agsl_pkg::PCM_W+1:0] out_data_q;
  logic [agsl_pkg::PCM_W+1:0] skid_data_q;
  logic                       pipe_take;
  logic                       out_free;

  assign pipe_ready = !skid_valid_q;
  assign pipe_take  = pipe_valid && pipe_ready;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= pipe_take;
      end
    end else if (pipe_take) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_valid_q ? skid_data_q : {pipe_word, pipe_ch, pipe_last};
    end else if (pipe_take) begin
      skid_data_q <= {pipe_word, pipe_ch, pipe_last};
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pcm_word_o    = out_data_q[agsl_pkg::PCM_W+1:2];
  assign channel_out_o = out_data_q[1];
  assign last_out_o    = out_data_q[0];

  `AGSL_ASSERT_IMP(a_skid_needs_out, skid_valid_q, out_valid_q)
  `AGSL_ASSERT_IMP(a_skid_on_stall, skid_valid_q && !$past(skid_valid_q), $past(out_valid_q && out_stall_i))
  `AGSL_ASSERT_NXT(a_empty_no_skid, !out_valid_q, !skid_valid_q)

endmodule
